>>> sv/spi_pkg.sv
// Shared types and constants for the stick pointer integrator.
// Used by spi_shsub and stick_pointer_integrator; no dependencies.
package spi_pkg;

    localparam int SU_STEP_W = 6;

    // Radial dead zone (0.15) in Q1.15 and the span that remains above it.
    localparam logic [15:0] DZ_Q15    = 16'd4915;
    localparam logic [15:0] ZONE_SPAN = 16'd27853;
    // ceil(2^46 / ZONE_SPAN): (m * ZONE_RECIP) >> 31 equals (m << 15) / ZONE_SPAN
    // exactly for every 16-bit m.
    localparam logic [31:0] ZONE_RECIP = 32'd2526433210;

    typedef enum logic [1:0] {
        CFG_SPEED  = 2'd0,
        CFG_CLICK  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        SU_DIV  = 1'b0,
        SU_SQRT = 1'b1
    } t_su_op;

    typedef struct packed {
        logic                 start;
        t_su_op               op;
        logic [SU_STEP_W-1:0] steps;
    } t_su_req;

endpackage

>>> sv/spi_shsub.sv
// Shared shift-subtract unit: restoring unsigned divide or integer square root,
// one quotient/root bit per cycle. Depends on spi_pkg.
module spi_shsub #(
    parameter int DW = 35
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spi_pkg::t_su_req   i_req,
    input  logic [DW-1:0]      i_num,   // left aligned operand
    input  logic [15:0]        i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    import spi_pkg::*;

    localparam int RW = 20;

    logic                 r_busy;
    logic                 r_done;
    logic [SU_STEP_W-1:0] r_cnt;
    t_su_op               r_op;
    logic [RW-1:0]        r_rem;
    logic [DW-1:0]        r_num;
    logic [DW-1:0]        r_acc;
    logic [15:0]          r_den;

    logic [RW-1:0] rp;
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] n_rem;

    always_comb begin
        if (r_op == SU_SQRT) begin
            rp    = {r_rem[RW-3:0], r_num[DW-1 -: 2]};
            trial = {r_acc[RW-3:0], 2'b01};
        end else begin
            rp    = {r_rem[RW-2:0], r_num[DW-1]};
            trial = RW'(r_den);
        end
        ge    = (rp >= trial);
        n_rem = ge ? (rp - trial) : rp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SU_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_rem <= '0;
            r_acc <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= {r_acc[DW-2:0], ge};
            r_num <= (r_op == SU_SQRT) ? (r_num << 2) : (r_num << 1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_acc;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding run");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("busy with zero steps left");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("start while a run is in progress");
`endif

endmodule

>>> sv/stick_pointer_integrator.sv
// Stick pointer integrator top level: frame sequencer, shared multiplier,
// position integration and clamp. Depends on spi_pkg and spi_shsub.
//
// Usage: one input word per video frame on s_axis (stick axes, mouse deltas,
// buttons, pad click); one result word per input on m_axis (cursor position,
// movement, button levels and edges). Configuration registers are written
// through i_cfg_we/i_cfg_addr/i_cfg_data; the user must do so only while the block
// is idle, which the block itself does not enforce. s_axis_tready is high only
// while the sequencer is idle; one word is in flight at a time. With speed zero
// the word goes straight to the output register; a stick inside the dead zone
// adds the square root of its magnitude; a stick outside it adds the rescale,
// the speed multiplies and the two direction divides as well. The square root
// and the divides run on the shared shift-subtract unit, one bit per cycle; the
// dead-zone rescale is a single reciprocal multiply. The next word can be taken
// in the cycle after a result is registered. A finished result sits in the output
// register; the next word is accepted meanwhile, and its result waits in the
// sequencer until m_axis_tready frees the register. Reset clears configuration,
// cursor, centring and button state.
module stick_pointer_integrator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // stick_x[15:0], stick_y[31:16], mouse_move_x[47:32], mouse_move_y[63:48],
    // mouse_buttons[66:64], pad_click[67], zero fill
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,
    // cursor_x, cursor_y, move_x, move_y, buttons_down, buttons_pressed,
    // buttons_released, from the lowest bit up, zero fill
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [((4*(COORD_BITS+FRAC_BITS)+11+7)/8)*8-1:0] m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_data
);
    import spi_pkg::*;

    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int MOV_W  = POS_W + 1;
    localparam int SW     = POS_W + 10;
    localparam int SPD_W  = 10 + FRAC_BITS;
    localparam int DV_W   = 27 + FRAC_BITS;
    localparam int DW     = (DV_W > 32) ? DV_W : 32;
    localparam int MB_W   = (SPD_W > 16) ? SPD_W : 16;
    localparam int PR_W   = 48;
    localparam int OUT_W  = ((4*POS_W+11+7)/8)*8;
    localparam logic signed [SW-1:0] POS_MAX = {{(SW-POS_W){1'b0}}, {POS_W{1'b1}}};

    typedef enum logic [4:0] {
        S_IDLE, S_CTR, S_SQX, S_SQY, S_SUM, S_RT_GO, S_RT_W, S_SCL,
        S_M1, S_M2, S_SPD, S_MX, S_DX_GO, S_DX_W, S_MY, S_DY_GO, S_DY_W,
        S_MOUSE, S_OUT
    } t_state;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SW-1:0] p,
                                                   input logic [11:0] scr);
        logic signed [SW-1:0] bnd;
        bnd = $signed({{(SW-12){1'b0}}, scr}) <<< FRAC_BITS;
        if (bnd > POS_MAX)
            bnd = POS_MAX;
        if (p < 0)
            return '0;
        else if (p > bnd)
            return bnd[POS_W-1:0];
        else
            return p[POS_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] centre_of(input logic [11:0] scr);
        logic signed [SW-1:0] v;
        v = $signed({{(SW-12){1'b0}}, scr}) <<< FRAC_BITS;
        return v >>> 1;
    endfunction

    // Normalized axis magnitude: full deflection maps to one, the most
    // negative code lands just beyond it.
    function automatic logic [16:0] axis_mag(input logic [15:0] s);
        if (s == 16'h7FFF || s == 16'h8001)
            return 17'd32768;
        else if (s == 16'h8000)
            return 17'd32769;
        else if (s[15])
            return 17'd0 - {1'b1, s};
        else
            return {1'b0, s};
    endfunction

    // configuration
    logic [15:0] r_speed;
    logic        r_click;
    logic [11:0] r_scr_w;
    logic [11:0] r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_click <= 1'b0;
            r_scr_w <= '0;
            r_scr_h <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SPEED:  r_speed <= i_cfg_data;
                CFG_CLICK:  r_click <= i_cfg_data[0];
                CFG_WIDTH:  r_scr_w <= i_cfg_data[11:0];
                CFG_HEIGHT: r_scr_h <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    t_state              r_state;
    logic                r_ovld;
    logic [OUT_W-1:0]    r_odata;
    logic [POS_W-1:0]    r_px;
    logic [POS_W-1:0]    r_py;
    logic [11:0]         r_cw;
    logic [11:0]         r_ch;
    logic [2:0]          r_last;

    logic [15:0]         r_sx;
    logic [15:0]         r_sy;
    logic [15:0]         r_mx;
    logic [15:0]         r_my;
    logic [2:0]          r_mb;
    logic                r_pad;

    logic [16:0]         r_ax;
    logic [16:0]         r_ay;
    logic                r_sgx;
    logic                r_sgy;
    logic [31:0]         r_sq;
    logic [15:0]         r_mag;
    logic [15:0]         r_scaled;
    logic [SPD_W-1:0]    r_spd;
    logic [PR_W-1:0]     r_prod;
    logic signed [SW-1:0] r_wx;
    logic signed [SW-1:0] r_wy;
    logic [POS_W-1:0]    r_prevx;
    logic [POS_W-1:0]    r_prevy;
    logic [MOV_W-1:0]    r_mvx;
    logic [MOV_W-1:0]    r_mvy;

    // shared multiplier
    logic [31:0]         mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [31+MB_W:0]    mul_p;

    // shift-subtract unit
    t_su_req             su_req;
    logic [DW-1:0]       su_num;
    logic [15:0]         su_den;
    logic                su_busy;
    logic                su_done;
    logic [DW-1:0]       su_quot;

    logic                in_acc;
    logic                recentre;
    logic [2:0]          now_btn;
    logic signed [SW-1:0] step_q;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic [POS_W-1:0]    new_x;
    logic [POS_W-1:0]    new_y;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign recentre = (r_scr_w != '0) && (r_scr_h != '0) &&
                      ((r_scr_w != r_cw) || (r_scr_h != r_ch));
    assign now_btn  = r_mb | {2'b00, (r_speed != '0) && r_click && r_pad};
    assign step_q   = $signed(SW'(su_quot[SPD_W-1:0]));

    assign sum_x = r_wx + ($signed({{(SW-16){r_mx[15]}}, r_mx}) <<< FRAC_BITS);
    assign sum_y = r_wy + ($signed({{(SW-16){r_my[15]}}, r_my}) <<< FRAC_BITS);
    assign new_x = clamp_pos(sum_x, r_scr_w);
    assign new_y = clamp_pos(sum_y, r_scr_h);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin
                mul_a = 32'(r_ax);
                mul_b = MB_W'(r_ax);
            end
            S_SQY: begin
                mul_a = 32'(r_ay);
                mul_b = MB_W'(r_ay);
            end
            S_SCL: begin
                mul_a = ZONE_RECIP;
                mul_b = MB_W'(r_mag - DZ_Q15);
            end
            S_M1: begin
                mul_a = 32'(r_scaled);
                mul_b = MB_W'(r_scaled);
            end
            S_M2: begin
                mul_a = r_prod[31:0];
                mul_b = MB_W'(r_speed);
            end
            S_MX: begin
                mul_a = 32'(r_ax);
                mul_b = MB_W'(r_spd);
            end
            S_MY: begin
                mul_a = 32'(r_ay);
                mul_b = MB_W'(r_spd);
            end
            default: ;
        endcase
        mul_p = (32+MB_W)'(mul_a) * (32+MB_W)'(mul_b);
    end

    always_comb begin
        su_req = '{start: 1'b0, op: SU_DIV, steps: '0};
        su_num = '0;
        su_den = r_mag;
        case (r_state)
            S_RT_GO: begin
                su_req = '{start: 1'b1, op: SU_SQRT, steps: SU_STEP_W'(16)};
                su_num = DW'(r_sq) << (DW-32);
            end
            S_DX_GO, S_DY_GO: begin
                su_req = '{start: 1'b1, op: SU_DIV, steps: SU_STEP_W'(DV_W)};
                su_num = DW'(r_prod[DV_W-1:0]) << (DW-DV_W);
            end
            default: ;
        endcase
    end

    spi_shsub #(
        .DW (DW)
    ) u_shsub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (su_req),
        .i_num   (su_num),
        .i_den   (su_den),
        .o_busy  (su_busy),
        .o_done  (su_done),
        .o_quot  (su_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_cw    <= '0;
            r_ch    <= '0;
            r_last  <= '0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_ovld && m_axis_tready && r_state != S_OUT)
                r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sx    <= s_axis_tdata[15:0];
                        r_sy    <= s_axis_tdata[31:16];
                        r_mx    <= s_axis_tdata[47:32];
                        r_my    <= s_axis_tdata[63:48];
                        r_mb    <= s_axis_tdata[66:64];
                        r_pad   <= s_axis_tdata[67];
                        r_state <= S_CTR;
                    end
                end
                S_CTR: begin
                    r_ax  <= axis_mag(r_sx);
                    r_ay  <= axis_mag(r_sy);
                    r_sgx <= r_sx[15];
                    r_sgy <= r_sy[15];
                    if (r_speed == '0) begin
                        r_mvx   <= '0;
                        r_mvy   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (recentre) begin
                            r_px    <= clamp_pos(centre_of(r_scr_w), r_scr_w);
                            r_py    <= clamp_pos(centre_of(r_scr_h), r_scr_h);
                            r_prevx <= clamp_pos(centre_of(r_scr_w), r_scr_w);
                            r_prevy <= clamp_pos(centre_of(r_scr_h), r_scr_h);
                            r_wx    <= $signed(SW'(clamp_pos(centre_of(r_scr_w), r_scr_w)));
                            r_wy    <= $signed(SW'(clamp_pos(centre_of(r_scr_h), r_scr_h)));
                            r_cw    <= r_scr_w;
                            r_ch    <= r_scr_h;
                        end else begin
                            r_prevx <= r_px;
                            r_prevy <= r_py;
                            r_wx    <= $signed(SW'(r_px));
                            r_wy    <= $signed(SW'(r_py));
                        end
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq    <= r_prod[31:0];
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sq    <= r_sq + r_prod[31:0];
                    r_state <= S_RT_GO;
                end
                S_RT_GO: r_state <= S_RT_W;
                S_RT_W: begin
                    if (su_done) begin
                        r_mag   <= su_quot[15:0];
                        r_state <= (su_quot[15:0] > DZ_Q15) ? S_SCL : S_MOUSE;
                    end
                end
                S_SCL: begin
                    r_scaled <= mul_p[46:31];
                    r_state  <= S_M1;
                end
                S_M1: begin
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_spd   <= SPD_W'(r_prod >> (38 - FRAC_BITS));
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_DX_GO;
                end
                S_DX_GO: r_state <= S_DX_W;
                S_DX_W: begin
                    if (su_done) begin
                        r_wx    <= r_sgx ? (r_wx - step_q) : (r_wx + step_q);
                        r_state <= S_MY;
                    end
                end
                S_MY: begin
                    r_prod  <= mul_p[PR_W-1:0];
                    r_state <= S_DY_GO;
                end
                S_DY_GO: r_state <= S_DY_W;
                S_DY_W: begin
                    if (su_done) begin
                        r_wy    <= r_sgy ? (r_wy - step_q) : (r_wy + step_q);
                        r_state <= S_MOUSE;
                    end
                end
                S_MOUSE: begin
                    r_px    <= new_x;
                    r_py    <= new_y;
                    r_mvx   <= MOV_W'(new_x) - MOV_W'(r_prevx);
                    r_mvy   <= MOV_W'(new_y) - MOV_W'(r_prevy);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_ovld  <= 1'b1;
                        r_odata <= OUT_W'({r_last & ~now_btn, now_btn & ~r_last, now_btn,
                                           r_mvy, r_mvx, r_py, r_px});
                        r_last  <= now_btn;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_done |-> (r_state == S_RT_W || r_state == S_DX_W || r_state == S_DY_W))
        else $error("divide/root result arrived outside a wait state");
    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !su_busy)
        else $error("shared unit still running while idle");
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == S_IDLE && !r_ovld))
        else $error("control state not cleared by reset");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for stick_pointer_integrator: directed table, then random frames.
// Depends on spi_pkg and the stick_pointer_integrator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spi_pkg::*;

    localparam int CB = 12;
    localparam int FB = 8;
    localparam int PB = CB + FB;
    localparam int OW = ((4*PB+11+7)/8)*8;
    localparam longint POS_TOP = (64'd1 << PB) - 1;
    localparam longint LIMIT = 3_000_000;

    localparam logic [15:0] DIR_SX [8] = '{16'h0, 16'h7fff, 16'h8000, 16'd1000,
                                           16'hfc18, 16'd6000, 16'h8000, 16'h7fff};
    localparam logic [15:0] DIR_SY [8] = '{16'h0, 16'h7fff, 16'h8000, 16'd1000,
                                           16'h0, 16'hec78, 16'h7fff, 16'h8000};

    typedef struct packed {
        logic [2:0]  rel;
        logic [2:0]  prs;
        logic [2:0]  dn;
        logic [PB:0] my;
        logic [PB:0] mx;
        logic [PB-1:0] cy;
        logic [PB-1:0] cx;
    } t_cursor;

    typedef struct {
        logic [15:0] sx, sy, dx, dy;
        logic [2:0]  btn;
        logic        pad;
        logic        has_exp;
        t_cursor     exp;
    } t_row;

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, m_axis_tready = 0;
    logic [71:0] s_axis_tdata = '0;
    logic s_axis_tready, m_axis_tvalid;
    logic [OW-1:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    stick_pointer_integrator #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    longint speed_q, clk_en, scr_w, scr_h, px, py, cen_w, cen_h, prev_btn;
    t_cursor cursor_q[$];
    int errors = 0;
    int send_idle = 0, recv_stall = 0;
    logic hold_off = 0;
    event hold_go;
    longint cycles = 0;

    function automatic longint sq_root(longint v);
        longint r;
        r = 0;
        for (longint b = 64'd1 << 62; b > 0; b >>= 2)
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
        return r;
    endfunction

    function automatic longint clamp(longint p, longint scr);
        longint bnd;
        bnd = scr << FB;
        if (bnd > POS_TOP) bnd = POS_TOP;
        if (p < 0) p = 0;
        if (p > bnd) p = bnd;
        return p;
    endfunction

    function automatic t_cursor integrate(t_row r);
        t_cursor c;
        longint ox, oy, nx, ny, mag, sc, spd, mvx, mvy;
        logic [2:0] now;
        now = r.btn;
        mvx = 0;
        mvy = 0;
        if (speed_q != 0) begin
            if (scr_w > 0 && scr_h > 0 && (scr_w != cen_w || scr_h != cen_h)) begin
                px = clamp((scr_w << FB) >> 1, scr_w);
                py = clamp((scr_h << FB) >> 1, scr_h);
                cen_w = scr_w;
                cen_h = scr_h;
            end
            ox = px;
            oy = py;
            nx = longint'($signed(r.sx)) * 32768 / 32767;
            ny = longint'($signed(r.sy)) * 32768 / 32767;
            mag = sq_root(nx * nx + ny * ny);
            if (mag > DZ_Q15) begin
                sc = ((mag - DZ_Q15) << 15) / ZONE_SPAN;
                spd = (sc * sc * speed_q) >> (38 - FB);
                px += nx * spd / mag;
                py += ny * spd / mag;
            end
            px = clamp(px + longint'($signed(r.dx)) * (1 << FB), scr_w);
            py = clamp(py + longint'($signed(r.dy)) * (1 << FB), scr_h);
            mvx = px - ox;
            mvy = py - oy;
            if (clk_en != 0 && r.pad) now[0] = 1'b1;
        end
        c.cx = px[PB-1:0];
        c.cy = py[PB-1:0];
        c.mx = mvx[PB:0];
        c.my = mvy[PB:0];
        c.dn = now;
        c.prs = now & ~prev_btn[2:0];
        c.rel = prev_btn[2:0] & ~now;
        prev_btn = now;
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_SPEED:  speed_q = val;
            CFG_CLICK:  clk_en = val[0];
            CFG_WIDTH:  scr_w = val[11:0];
            CFG_HEIGHT: scr_h = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (cursor_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // leaves tvalid high after the accepting edge; drain or an idle gap in the next call drops it
    task automatic send_frame(t_row r);
        t_cursor c;
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {4'd0, r.pad, r.btn, r.dy, r.dx, r.sy, r.sx};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        c = integrate(r);
        if (r.has_exp && c != r.exp) begin
            $display("%0t directed row predictor disagrees: exp %h got %h", $time, r.exp, c);
            errors++;
        end
        cursor_q.push_back(r.has_exp ? r.exp : c);
    endtask

    function automatic t_row rand_row();
        t_row r;
        int k;
        k = int'($urandom_range(9));
        r.sx = 16'($urandom);
        r.sy = 16'($urandom);
        if (k < 3) begin
            r.sx = 16'($urandom_range(3000) - 1500);
            r.sy = 16'($urandom_range(3000) - 1500);
        end
        if (k == 3) r.sx = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        r.dx = (k < 7) ? 16'($urandom_range(40) - 20) : 16'($urandom);
        r.dy = (k < 7) ? 16'($urandom_range(40) - 20) : 16'($urandom);
        r.btn = 3'($urandom);
        r.pad = 1'($urandom);
        r.has_exp = 0;
        return r;
    endfunction

    // long receiver hold-off, counted here
    always begin
        @(hold_go);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // receiver
    always @(posedge i_clk) begin
        t_cursor got, want;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_cursor)-1:0];
            if (cursor_q.size() == 0) begin
                $display("%0t unexpected word: got %h", $time, got);
                errors++;
            end else begin
                want = cursor_q.pop_front();
                if (got.cx !== want.cx || got.cy !== want.cy || got.mx !== want.mx ||
                    got.my !== want.my || got.dn !== want.dn || got.prs !== want.prs ||
                    got.rel !== want.rel) begin
                    $display("%0t mismatch: exp %h got %h", $time, want, got);
                    errors++;
                end
            end
        end
        m_axis_tready <= !hold_off && !(recv_stall != 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge i_clk)
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end

    t_row dir[$];

    initial begin
        t_row r;
        int rnd_per;
        speed_q = 0; clk_en = 0; scr_w = 0; scr_h = 0;
        px = 0; py = 0; cen_w = 0; cen_h = 0; prev_btn = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // after reset, speed zero: frozen cursor, buttons only
        r = '{16'h7fff, 16'h7fff, 16'h0100, 16'h0100, 3'd5, 1'b1, 1'b1,
              '{rel: 0, prs: 5, dn: 5, my: 0, mx: 0, cy: 0, cx: 0}};
        send_frame(r);
        r = '{16'h8000, 16'h0000, 16'h8000, 16'h7fff, 3'd2, 1'b0, 1'b1,
              '{rel: 5, prs: 2, dn: 2, my: 0, mx: 0, cy: 0, cx: 0}};
        send_frame(r);
        drain();

        // screen size zero with speed set: no recentring, clamp to zero
        write_reg(CFG_SPEED, 16'h0100);
        write_reg(CFG_CLICK, 16'd1);
        r = '{16'h7fff, 16'h0, 16'h0010, 16'h0010, 3'd0, 1'b1, 1'b1,
              '{rel: 2, prs: 1, dn: 1, my: 0, mx: 0, cy: 0, cx: 0}};
        send_frame(r);
        drain();

        write_reg(CFG_WIDTH, 16'd640);
        write_reg(CFG_HEIGHT, 16'd480);
        dir = {};
        for (int i = 0; i < 8; i++) begin
            r = '{DIR_SX[i], DIR_SY[i], 16'(i * 3 - 10), 16'(7 - i), 3'(i), 1'(i), 1'b0, '0};
            dir.push_back(r);
        end
        // mouse extremes hit both clamp edges
        r = '{16'h0, 16'h0, 16'h7fff, 16'h8000, 3'd7, 1'b0, 1'b0, '0};
        dir.push_back(r);
        r = '{16'h0, 16'h0, 16'h8000, 16'h7fff, 3'd0, 1'b1, 1'b0, '0};
        dir.push_back(r);
        foreach (dir[i]) send_frame(dir[i]);
        drain();

        // extremes: full speed, widest screen, then speed zero
        write_reg(CFG_SPEED, 16'hffff);
        write_reg(CFG_WIDTH, 16'd4095);
        write_reg(CFG_HEIGHT, 16'd4095);
        for (int i = 0; i < 6; i++) send_frame(rand_row());
        drain();
        write_reg(CFG_SPEED, 16'd0);
        for (int i = 0; i < 3; i++) send_frame(rand_row());
        drain();

        // random phases, each with its own configuration
        rnd_per = 1750 / 8;
        for (int ph = 0; ph < 8; ph++) begin
            send_idle = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 30 : 46) : 0;
            recv_stall = (ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 30 : 0;
            write_reg(CFG_SPEED, (ph == 7) ? 16'd0 : 16'($urandom_range(1, 65535)));
            write_reg(CFG_CLICK, 16'($urandom_range(1)));
            write_reg(CFG_WIDTH, (ph == 5) ? 16'd0 : 16'($urandom_range(4095)));
            write_reg(CFG_HEIGHT, 16'($urandom_range(1, 4095)));
            if (ph == 2) -> hold_go;
            for (int i = 0; i < rnd_per; i++) send_frame(rand_row());
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
